// File: hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 16;

    typedef logic [1:0] status_t;
    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_PLACE,
        S_HEAD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
    } entry_t;

endpackage

// File: hw/rtl/spq_ram.sv
// Single-port-write, single-port-read entry memory with registered read data.
module spq_ram
(
    input  logic                  clk,
    input  logic                  we,
    input  logic [spq_pkg::ADDR_W-1:0] waddr,
    input  spq_pkg::entry_t       wdata,
    input  logic [spq_pkg::ADDR_W-1:0] raddr,
    output spq_pkg::entry_t       rdata
);
    import spq_pkg::*;

    entry_t mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: sequencer around one entry memory.
//
// Usage: drive kind, entry_key and entry_payload with start high while busy
// is low; the request is taken at that edge. One result follows, shown for
// exactly one cycle with done high: status, removed entry, head and count.
// Entries sit in descending key order in one memory, head at address 0.
// An insert reads entries from the tail toward the head, each read followed
// by a compare and write back, moving each entry with a key not greater than
// the new one up one place until the slot is found, then writes the new entry
// and reads back the head. A remove reads entries from the head toward the
// tail, moving each down. Refused requests (full insert, empty remove) skip
// the scan and go straight to the head read.
// One request is processed at a time; busy stays high until done.
// Reset clears the count and control; memory contents need no clearing.
// The receiver cannot stall: each result appears once and must be taken.
module sorted_priority_queue
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        kind,
    input  logic signed [31:0]          entry_key,
    input  logic [15:0]                 entry_payload,
    output logic                        done,
    output logic [1:0]                  status,
    output logic signed [31:0]          out_key,
    output logic [15:0]                 out_payload,
    output logic signed [31:0]          head_key,
    output logic [15:0]                 head_payload,
    output logic [6:0]                  item_count,
    output logic                        is_empty
);
    import spq_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              kind_reg;
    entry_t            new_reg;
    status_t           status_reg, status_next;
    entry_t            out_reg, out_next;
    logic              in_wr;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    entry_t            wdata, rdata;

    spq_ram u_ram
    (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign in_wr = start && !busy;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        out_next    = out_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_wr)
                begin
                    status_next = ST_DONE;
                    out_next    = '0;
                    if (kind == KIND_INSERT)
                    begin
                        if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_HEAD;
                        end
                        else if (count_reg == '0)
                        begin
                            idx_next   = '0;
                            state_next = S_PLACE;
                        end
                        else
                        begin
                            idx_next   = count_reg - 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_HEAD;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (kind_reg == KIND_INSERT)
                begin
                    if (new_reg.key >= rdata.key)
                    begin
                        if (idx_reg == '0)
                        begin
                            state_next = S_PLACE;
                        end
                        else
                        begin
                            idx_next   = idx_reg - 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    if (idx_reg == '0)
                    begin
                        out_next = rdata;
                    end
                    if (idx_reg + 1'b1 >= count_reg)
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = S_HEAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_PLACE:
            begin
                count_next = count_reg + 1'b1;
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg[ADDR_W-1:0];
        wdata = rdata;
        raddr = idx_reg[ADDR_W-1:0];
        unique case (state_reg)
            S_SHIFT:
            begin
                if (kind_reg == KIND_INSERT)
                begin
                    we    = !(new_reg.key >= rdata.key) ? 1'b0 : 1'b1;
                    waddr = ADDR_W'(idx_reg + 1'b1);
                end
                else
                begin
                    we    = (idx_reg != '0);
                    waddr = ADDR_W'(idx_reg - 1'b1);
                end
            end
            S_PLACE:
            begin
                we    = 1'b1;
                wdata = new_reg;
            end
            S_HEAD:
            begin
                raddr = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            status_reg <= ST_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (in_wr)
        begin
            kind_reg <= kind;
            new_reg  <= '{key: entry_key, payload: entry_payload};
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = (state_reg == S_DONE);
    assign status       = status_reg;
    assign out_key      = out_reg.key;
    assign out_payload  = out_reg.payload;
    assign is_empty     = (count_reg == '0);
    assign head_key     = is_empty ? '0 : rdata.key;
    assign head_payload = is_empty ? '0 : rdata.payload;
    assign item_count   = count_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_done_after_head: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_HEAD))
        else $error("result without head read");

    a_refused_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg != ST_DONE) |-> $stable(count_reg))
        else $error("refused request changed count");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the sorted priority queue: directed and random request traffic, scoreboard.
module testbench;
    import spq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        kind;
        logic [31:0] key;
        logic [15:0] payload;
    } request_t;

    typedef struct {
        status_t     status;
        logic [31:0] out_key;
        logic [15:0] out_payload;
        logic [31:0] head_key;
        logic [15:0] head_payload;
        logic [6:0]  item_count;
        logic        is_empty;
    } response_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        kind;
    logic signed [31:0] entry_key;
    logic [15:0] entry_payload;
    logic        done;
    logic [1:0]  status;
    logic signed [31:0] out_key;
    logic [15:0] out_payload;
    logic signed [31:0] head_key;
    logic [15:0] head_payload;
    logic [6:0]  item_count;
    logic        is_empty;

    request_t    pending_requests[$];
    response_t   expected_responses[$];
    logic [31:0] queue_keys[$];
    logic [15:0] queue_payloads[$];
    int          mismatches = 0;
    int          idle_cycles;
    int          quiet_cycles = 0;
    int          sent_count;
    int          total_requests;

    sorted_priority_queue u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .entry_key    (entry_key),
        .entry_payload(entry_payload),
        .done         (done),
        .status       (status),
        .out_key      (out_key),
        .out_payload  (out_payload),
        .head_key     (head_key),
        .head_payload (head_payload),
        .item_count   (item_count),
        .is_empty     (is_empty)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic response_t apply_request(request_t r);
        response_t rsp;
        int        pos;
        rsp = '{ST_DONE, '0, '0, '0, '0, '0, 1'b0};
        if (r.kind == KIND_INSERT) begin
            if (queue_keys.size() >= CAPACITY) begin
                rsp.status = ST_FULL;
            end
            else begin
                pos = 0;
                while (pos < queue_keys.size() && $signed(r.key) < $signed(queue_keys[pos]))
                    pos++;
                queue_keys.insert(pos, r.key);
                queue_payloads.insert(pos, r.payload);
            end
        end
        else begin
            if (queue_keys.size() == 0) begin
                rsp.status = ST_EMPTY;
            end
            else begin
                rsp.out_key = queue_keys.pop_front();
                rsp.out_payload = queue_payloads.pop_front();
            end
        end
        if (queue_keys.size() > 0) begin
            rsp.head_key = queue_keys[0];
            rsp.head_payload = queue_payloads[0];
        end
        rsp.item_count = 7'(queue_keys.size());
        rsp.is_empty = (queue_keys.size() == 0);
        return rsp;
    endfunction

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 7) << 16;
            3: return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_request(logic k, logic [31:0] key, logic [15:0] pay);
        request_t r;
        r.kind = k;
        r.key = key;
        r.payload = pay;
        pending_requests.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start <= 1'b0;
            kind <= KIND_INSERT;
            entry_key <= '0;
            entry_payload <= '0;
            idle_cycles <= 0;
            sent_count <= 0;
        end
        else begin
            if (start && !busy) begin
                expected_responses.push_back(apply_request('{kind, entry_key, entry_payload}));
                sent_count <= sent_count + 1;
            end
            if (start && busy) begin
                // hold request until accepted
            end
            else if (idle_cycles > 0) begin
                idle_cycles <= idle_cycles - 1;
                start <= 1'b0;
            end
            else if (pending_requests.size() > 0 && sent_count < total_requests * 9 / 10
                     && $urandom_range(0, 5) == 0) begin
                idle_cycles <= $urandom_range(1, 8) - 1;
                start <= 1'b0;
            end
            else if (pending_requests.size() > 0) begin
                request_t r;
                r = pending_requests.pop_front();
                start <= 1'b1;
                kind <= r.kind;
                entry_key <= r.key;
                entry_payload <= r.payload;
            end
            else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && done) begin
            if (expected_responses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response at %0t", $realtime);
            end
            else begin
                response_t e;
                e = expected_responses.pop_front();
                if (status !== e.status || out_key !== e.out_key
                    || out_payload !== e.out_payload || head_key !== e.head_key
                    || head_payload !== e.head_payload || item_count !== e.item_count
                    || is_empty !== e.is_empty) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp st=%0d ok=%h op=%h hk=%h hp=%h n=%0d e=%b",
                                 e.status, e.out_key, e.out_payload, e.head_key,
                                 e.head_payload, e.item_count, e.is_empty);
                        $display("          act st=%0d ok=%h op=%h hk=%h hp=%h n=%0d e=%b",
                                 status, out_key, out_payload, head_key,
                                 head_payload, item_count, is_empty);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 2000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int level;
        int burst;
        rst_n = 1'b0;
        add_request(KIND_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
        add_request(KIND_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
        add_request(KIND_INSERT, 32'h8000_0000, 16'h0000);
        add_request(KIND_INSERT, 32'h0001_0000, 16'h0001);
        add_request(KIND_INSERT, 32'h0001_0000, 16'h0002);
        add_request(KIND_INSERT, 32'hFFFF_0000, 16'h5A5A);
        add_request(KIND_INSERT, 32'h7FFF_FFFF, 16'hA5A5);
        for (int i = 0; i < 8; i++)
            add_request(KIND_REMOVE, $urandom, $urandom);
        for (int i = 0; i < CAPACITY + 2; i++)
            add_request(KIND_INSERT, pick_key(), $urandom);
        for (int i = 0; i < CAPACITY + 2; i++)
            add_request(KIND_REMOVE, $urandom, $urandom);
        level = 0;
        while (pending_requests.size() < 700) begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst; i++) begin
                if ((level < 32) ? ($urandom_range(0, 2) != 0) : ($urandom_range(0, 2) == 0))
                    add_request(KIND_INSERT, pick_key(), $urandom);
                else
                    add_request(KIND_REMOVE, pick_key(), $urandom);
            end
            level = $urandom_range(0, 64);
        end
        total_requests = pending_requests.size();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_requests.size() == 0 && !start);
        wait (expected_responses.size() == 0);
        repeat (CAPACITY + 10) @(posedge clk);
        if (mismatches == 0 && expected_responses.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
